// ===== rtl/ssc_pkg.sv =====
// Shared types and constants for the speed segment cost pipeline.
package ssc_pkg;

    localparam int MAX_RANGES = 8;
    localparam int POS_BITS   = 18;
    localparam int CNT_W      = $clog2(MAX_RANGES + 1);
    localparam int IDX_W      = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;

    localparam int SPEED_W    = POS_BITS + 8;
    localparam int Q_BITS     = 32;
    localparam int DIV_STEPS  = 4;
    localparam int DIV_STAGES = Q_BITS / DIV_STEPS;
    localparam int LATENCY    = 3 + DIV_STAGES + 4;

    localparam logic [31:0] COST_MAX = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_EVAL  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_REVERSE    = 2'd1,
        ST_FULL       = 2'd2,
        ST_ZERO_LIMIT = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        CFG_INV_TIME_STEP  = 3'd0,
        CFG_STOP_SPEED     = 3'd1,
        CFG_OVER_WEIGHT    = 3'd2,
        CFG_UNDER_WEIGHT   = 3'd3,
        CFG_NO_STOP_WEIGHT = 3'd4,
        CFG_CRUISE_WEIGHT  = 3'd5,
        CFG_CRUISE_ENABLE  = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic                 calc;
        t_status              status;
        logic                 in_ns;
        logic                 ns_add;
        logic                 over;
        logic                 under;
        logic                 ovf;
        logic [15:0]          limit;
        logic [15:0]          target;
        logic [SPEED_W-1:0]   cdiff;
    } t_ctx;

    typedef struct packed {
        logic [16:0]       rem;
        logic [Q_BITS-1:0] num;
        logic [Q_BITS-1:0] quo;
    } t_div;

endpackage

// ===== rtl/speed_segment_cost.sv =====
// An item's result strobes out after passing the stage 1-3, divider, M1-M3 and output registers.
// Throughput: one item per cycle; o_busy stays low, since the receiver cannot stall.
// The relative deviation comes from a restoring divider that resolves four quotient
// bits per stage over eight stages, which sets most of the pipeline depth.
// Reset (synchronous, active low) empties the pipeline, clears the range count and
// loads the register reset values; the range table itself is not cleared.
module speed_segment_cost
    import ssc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_addr,
    input  logic [31:0]         i_cfg_wdata,
    input  logic                i_start,
    output logic                o_busy,
    input  logic [1:0]          i_cmd,
    input  logic [POS_BITS-1:0] i_prev_pos,
    input  logic [POS_BITS-1:0] i_curr_pos,
    input  logic [15:0]         i_limit_speed,
    input  logic [15:0]         i_target_speed,
    input  logic [POS_BITS-1:0] i_range_lo,
    input  logic [POS_BITS-1:0] i_range_hi,
    output logic                o_valid,
    output logic [31:0]         o_step_cost,
    output logic [1:0]          o_status
);

    // Configuration registers
    logic [15:0] r_inv_time_step, r_stop_speed;
    logic [31:0] r_over_weight, r_under_weight, r_no_stop_weight, r_cruise_weight;
    logic        r_cruise_enable;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_time_step  <= 16'd256;
            r_stop_speed     <= 16'd205;
            r_over_weight    <= '0;
            r_under_weight   <= '0;
            r_no_stop_weight <= '0;
            r_cruise_weight  <= '0;
            r_cruise_enable  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_INV_TIME_STEP:  r_inv_time_step  <= i_cfg_wdata[15:0];
                CFG_STOP_SPEED:     r_stop_speed     <= i_cfg_wdata[15:0];
                CFG_OVER_WEIGHT:    r_over_weight    <= i_cfg_wdata;
                CFG_UNDER_WEIGHT:   r_under_weight   <= i_cfg_wdata;
                CFG_NO_STOP_WEIGHT: r_no_stop_weight <= i_cfg_wdata;
                CFG_CRUISE_WEIGHT:  r_cruise_weight  <= i_cfg_wdata;
                CFG_CRUISE_ENABLE:  r_cruise_enable  <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign o_busy = 1'b0;

    logic accept;
    assign accept = i_start && !o_busy;

    // Range table; entries at or above the count are never looked at.
    logic [POS_BITS-1:0] r_rs [MAX_RANGES];
    logic [POS_BITS-1:0] r_re [MAX_RANGES];
    logic [CNT_W-1:0]    r_count;
    logic                full;
    logic                in_ns;

    assign full = (r_count >= CNT_W'(MAX_RANGES));

    always_comb begin
        in_ns = 1'b0;
        for (int i = 0; i < MAX_RANGES; i++) begin
            if ((CNT_W'(i) < r_count) && (r_rs[i] <= i_curr_pos) && (r_re[i] >= i_curr_pos))
                in_ns = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (accept) begin
            if (i_cmd == CMD_CLEAR)
                r_count <= '0;
            else if (i_cmd == CMD_ADD && !full)
                r_count <= r_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_cmd == CMD_ADD && !full) begin
            r_rs[r_count[IDX_W-1:0]] <= i_range_lo;
            r_re[r_count[IDX_W-1:0]] <= i_range_hi;
        end
    end

    // Stage 1: classify the item and take the position delta.
    t_ctx n_ctx1, r_ctx1, r_ctx2;
    logic [POS_BITS-1:0] r_delta;
    logic                r_v1, r_v2;

    always_comb begin
        n_ctx1        = '0;
        n_ctx1.in_ns  = in_ns;
        n_ctx1.limit  = i_limit_speed;
        n_ctx1.target = i_target_speed;
        n_ctx1.status = ST_OK;
        case (i_cmd)
            CMD_ADD:  n_ctx1.status = full ? ST_FULL : ST_OK;
            CMD_EVAL: begin
                if (i_curr_pos < i_prev_pos)
                    n_ctx1.status = ST_REVERSE;
                else if (i_limit_speed == 16'd0)
                    n_ctx1.status = ST_ZERO_LIMIT;
                else
                    n_ctx1.calc = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_ctx1  <= n_ctx1;
        r_delta <= i_curr_pos - i_prev_pos;
    end

    // Stage 2: speed = delta * inv_time_step / 256.
    logic [SPEED_W-1:0] r_speed;
    logic [POS_BITS+15:0] speed_prod;
    assign speed_prod = r_delta * r_inv_time_step;

    always_ff @(posedge i_clk) begin
        r_ctx2  <= r_ctx1;
        r_speed <= speed_prod[POS_BITS+15:8];
    end

    // Stage 3: compare with limits and load the divider.
    t_ctx               n_ctx3;
    logic [SPEED_W-1:0] ldiff;
    t_div               n_div0;

    always_comb begin
        n_ctx3        = r_ctx2;
        n_ctx3.over   = (r_speed > SPEED_W'(r_ctx2.limit));
        n_ctx3.under  = (r_speed < SPEED_W'(r_ctx2.limit));
        ldiff         = n_ctx3.over ? (r_speed - SPEED_W'(r_ctx2.limit))
                                    : (SPEED_W'(r_ctx2.limit) - r_speed);
        // The quotient cannot fit in 32 bits once diff reaches limit * 2^16.
        n_ctx3.ovf    = ({{(48-SPEED_W){1'b0}}, ldiff} >= {16'd0, r_ctx2.limit, 16'd0});
        n_ctx3.ns_add = (r_speed < SPEED_W'(r_stop_speed)) && r_ctx2.in_ns;
        n_ctx3.cdiff  = (r_speed >= SPEED_W'(r_ctx2.target))
                        ? (r_speed - SPEED_W'(r_ctx2.target))
                        : (SPEED_W'(r_ctx2.target) - r_speed);
        n_div0.rem    = 17'(ldiff[SPEED_W-1:16]);
        n_div0.num    = {ldiff[15:0], 16'd0};
        n_div0.quo    = '0;
    end

    // Divider stages, index 0 is the stage 3 register.
    t_ctx r_dctx [DIV_STAGES+1];
    t_div r_div  [DIV_STAGES+1];
    logic r_dv   [DIV_STAGES+1];
    t_div n_div  [DIV_STAGES+1];

    function automatic t_div div_chunk(t_div d, logic [15:0] lim);
        t_div        t;
        logic [16:0] sh;
        t = d;
        for (int s = 0; s < DIV_STEPS; s++) begin
            sh    = {t.rem[15:0], t.num[Q_BITS-1]};
            t.num = {t.num[Q_BITS-2:0], 1'b0};
            if (sh >= {1'b0, lim}) begin
                t.rem = sh - {1'b0, lim};
                t.quo = {t.quo[Q_BITS-2:0], 1'b1};
            end else begin
                t.rem = sh;
                t.quo = {t.quo[Q_BITS-2:0], 1'b0};
            end
        end
        return t;
    endfunction

    always_comb begin
        n_div[0] = n_div0;
        for (int k = 1; k <= DIV_STAGES; k++)
            n_div[k] = div_chunk(r_div[k-1], r_dctx[k-1].limit);
    end

    always_ff @(posedge i_clk) begin
        r_dctx[0] <= n_ctx3;
        for (int k = 0; k <= DIV_STAGES; k++)
            r_div[k] <= n_div[k];
        for (int k = 1; k <= DIV_STAGES; k++)
            r_dctx[k] <= r_dctx[k-1];
    end

    // M1: products on the quotient and the cruise deviation.
    t_ctx         r_mctx1, r_mctx2, r_mctx3;
    logic         r_vm1, r_vm2, r_vm3;
    logic [63:0]  r_sq;
    logic [48:0]  r_uprod;
    logic [SPEED_W+31:0] r_cprod, r_cprod2;
    logic [Q_BITS-1:0]   q;

    assign q = r_div[DIV_STAGES].quo;

    always_ff @(posedge i_clk) begin
        r_mctx1 <= r_dctx[DIV_STAGES];
        r_sq    <= q * q;
        r_uprod <= r_under_weight * q[16:0];
        r_cprod <= r_cruise_weight * r_dctx[DIV_STAGES].cdiff;
    end

    // M2: over weight against the two halves of the square.
    // The square is first floored to Q16.16, so its low 16 bits never count.
    logic [63:0] r_opart;
    logic [47:0] r_olo;
    logic [48:0] r_uprod2;

    always_ff @(posedge i_clk) begin
        r_mctx2  <= r_mctx1;
        r_opart  <= r_over_weight * r_sq[63:32];
        r_olo    <= r_over_weight * r_sq[31:16];
        r_uprod2 <= r_uprod;
        r_cprod2 <= r_cprod;
    end

    // M3: saturate each term.
    logic [31:0] n_over_t, n_under_t, n_cruise_t;
    logic [31:0] r_over_t, r_under_t, r_cruise_t;
    logic [32:0] osum;

    always_comb begin
        osum = {1'b0, r_opart[31:0]} + 33'(r_olo[47:16]);
        if (r_over_weight == 32'd0)
            n_over_t = '0;
        else if (r_mctx2.ovf || (|r_opart[63:32]) || osum[32])
            n_over_t = COST_MAX;
        else
            n_over_t = osum[31:0];
        n_under_t  = r_uprod2[48] ? COST_MAX : r_uprod2[47:16];
        n_cruise_t = (|r_cprod2[SPEED_W+31:42]) ? COST_MAX : r_cprod2[41:10];
    end

    always_ff @(posedge i_clk) begin
        r_mctx3    <= r_mctx2;
        r_over_t   <= n_over_t;
        r_under_t  <= n_under_t;
        r_cruise_t <= n_cruise_t;
    end

    // Output stage: saturating sum of the enabled terms; infeasible steps saturate, other commands give zero.
    logic [33:0] total;
    logic [31:0] n_cost;

    always_comb begin
        total = {2'b0, (r_mctx3.ns_add ? r_no_stop_weight : 32'd0)}
              + {2'b0, (r_mctx3.over ? r_over_t : (r_mctx3.under ? r_under_t : 32'd0))}
              + {2'b0, (r_cruise_enable ? r_cruise_t : 32'd0)};
        if (r_mctx3.calc)
            n_cost = (|total[33:32]) ? COST_MAX : total[31:0];
        else if (r_mctx3.status == ST_REVERSE || r_mctx3.status == ST_ZERO_LIMIT)
            n_cost = COST_MAX;
        else
            n_cost = '0;
    end

    always_ff @(posedge i_clk) begin
        o_step_cost <= n_cost;
        o_status    <= r_mctx3.status;
    end

    // Valid bits travel alongside the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            for (int k = 0; k <= DIV_STAGES; k++)
                r_dv[k] <= 1'b0;
            r_vm1   <= 1'b0;
            r_vm2   <= 1'b0;
            r_vm3   <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_v1    <= accept;
            r_v2    <= r_v1;
            r_dv[0] <= r_v2;
            for (int k = 1; k <= DIV_STAGES; k++)
                r_dv[k] <= r_dv[k-1];
            r_vm1   <= r_dv[DIV_STAGES];
            r_vm2   <= r_vm1;
            r_vm3   <= r_vm2;
            o_valid <= r_vm3;
        end
    end

endmodule

// ===== rtl/ssc_checker.sv =====
// Port-level checker for the speed segment cost block and its bind.
module ssc_checker
    import ssc_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_start,
    input logic        o_busy,
    input logic [1:0]  i_cmd,
    input logic        o_valid,
    input logic [31:0] o_step_cost,
    input logic [1:0]  o_status
);

    // Every accepted item comes out after the fixed latency.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##LATENCY o_valid)
        else $error("accepted item did not produce a result");

    // No result appears without an accepted item.
    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_start && !o_busy) |-> ##LATENCY !o_valid)
        else $error("result without an accepted item");

    // Infeasible steps carry the saturated cost.
    a_infeasible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_REVERSE || o_status == ST_ZERO_LIMIT))
            |-> o_step_cost == COST_MAX)
        else $error("infeasible step without saturated cost");

    // A clear item answers with zero cost and ok status.
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_cmd == CMD_CLEAR)
            |-> ##LATENCY (o_valid && o_step_cost == 32'd0 && o_status == ST_OK))
        else $error("clear item gave a wrong result");

endmodule

bind speed_segment_cost ssc_checker u_ssc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_start     (i_start),
    .o_busy      (o_busy),
    .i_cmd       (i_cmd),
    .o_valid     (o_valid),
    .o_step_cost (o_step_cost),
    .o_status    (o_status)
);

// ===== dv/tb_speed_segment_cost.sv =====
// Self-checking testbench for speed_segment_cost: directed tables, then random phases.
module tb_speed_segment_cost;
    import ssc_pkg::*;

    typedef struct {
        t_cmd        cmd;
        logic [17:0] prev, curr, lo, hi;
        logic [15:0] lim, tgt;
        bit          typed;
        logic [31:0] cost;
        t_status     status;
    } t_row;

    typedef struct {
        logic [31:0] cost;
        t_status     status;
    } t_cost_result;

    logic i_clk, i_rst_n, i_cfg_we, i_start;
    logic [2:0] i_cfg_addr;
    logic [31:0] i_cfg_wdata;
    logic [1:0] i_cmd;
    logic [17:0] i_prev_pos, i_curr_pos, i_range_lo, i_range_hi;
    logic [15:0] i_limit_speed, i_target_speed;
    logic o_busy, o_valid;
    logic [31:0] o_step_cost;
    logic [1:0] o_status;

    speed_segment_cost dut (.*);

    // Local copy of the block's registers and range table.
    longint unsigned inv_step, stop_spd, w_over, w_under, w_nostop, w_cruise;
    bit cruise_on;
    longint unsigned zone_lo[MAX_RANGES], zone_hi[MAX_RANGES];
    int zone_count;

    t_cost_result pending_costs[$];
    int errors = 0;
    bit no_idle = 0;

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #400000;
        $display("simulation failed");
        $finish;
    end

    function automatic longint unsigned sat_sum(longint unsigned a, longint unsigned b);
        longint unsigned s;
        s = a + b;
        return (s > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : s;
    endfunction

    function automatic longint unsigned scaled_mul(longint unsigned w, longint unsigned x,
                                                   int sh);
        longint unsigned hi_part, lo_part, prod;
        hi_part = x >> sh;
        lo_part = x & ((64'd1 << sh) - 1);
        if (w == 0) return 0;
        if (hi_part > 64'hFFFF_FFFF) return 64'hFFFF_FFFF;
        prod = w * hi_part;
        if (prod > 64'hFFFF_FFFF) return 64'hFFFF_FFFF;
        return sat_sum(prod, (w * lo_part) >> sh);
    endfunction

    task automatic score_step(input t_row r, output t_cost_result res);
        longint unsigned c, spd, lim, det, diff;
        bit hit;
        c = 0;
        res.status = ST_OK;
        lim = r.lim;
        case (r.cmd)
            CMD_CLEAR: zone_count = 0;
            CMD_ADD: begin
                if (zone_count < MAX_RANGES) begin
                    zone_lo[zone_count] = r.lo;
                    zone_hi[zone_count] = r.hi;
                    zone_count++;
                end else begin
                    res.status = ST_FULL;
                end
            end
            CMD_EVAL: begin
                if (r.curr < r.prev) begin
                    c = 64'hFFFF_FFFF;
                    res.status = ST_REVERSE;
                end else if (lim == 0) begin
                    c = 64'hFFFF_FFFF;
                    res.status = ST_ZERO_LIMIT;
                end else begin
                    spd = ((r.curr - r.prev) * inv_step) >> 8;
                    hit = 0;
                    for (int i = 0; i < zone_count; i++)
                        if (zone_lo[i] <= r.curr && zone_hi[i] >= r.curr) hit = 1;
                    if (spd < stop_spd && hit) c = sat_sum(c, w_nostop);
                    if (spd > lim) begin
                        det = ((spd - lim) << 16) / lim;
                        if (det > 64'hFFFF_FFFF) begin
                            if (w_over != 0) c = 64'hFFFF_FFFF;
                        end else begin
                            c = sat_sum(c, scaled_mul(w_over, (det * det) >> 16, 16));
                        end
                    end else if (spd < lim) begin
                        det = ((lim - spd) << 16) / lim;
                        c = sat_sum(c, scaled_mul(w_under, det, 16));
                    end
                    if (cruise_on) begin
                        diff = (spd >= r.tgt) ? spd - r.tgt : r.tgt - spd;
                        c = sat_sum(c, scaled_mul(w_cruise, diff, 10));
                    end
                end
            end
            default: ;
        endcase
        res.cost = c[31:0];
    endtask

    // Called just after a falling edge; returns just after the falling edge that follows
    // acceptance or an idle gap. Start stays high so back-to-back items need no toggle.
    task automatic send_item(input t_row r);
        t_cost_result res;
        i_start = 1;
        i_cmd = r.cmd;
        i_prev_pos = r.prev;
        i_curr_pos = r.curr;
        i_limit_speed = r.lim;
        i_target_speed = r.tgt;
        i_range_lo = r.lo;
        i_range_hi = r.hi;
        do @(posedge i_clk); while (o_busy);
        score_step(r, res);
        if (r.typed) begin
            res.cost = r.cost;
            res.status = r.status;
        end
        pending_costs.push_back(res);
        @(negedge i_clk);
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            i_start = 0;
            i_cmd = 2'($urandom);
            i_prev_pos = 18'($urandom);
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        i_start = 0;
        while (pending_costs.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 2) @(negedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [31:0] v);
        i_cfg_we = 1;
        i_cfg_addr = idx;
        i_cfg_wdata = v;
        @(posedge i_clk);
        case (idx)
            CFG_INV_TIME_STEP:  inv_step = v[15:0];
            CFG_STOP_SPEED:     stop_spd = v[15:0];
            CFG_OVER_WEIGHT:    w_over = v;
            CFG_UNDER_WEIGHT:   w_under = v;
            CFG_NO_STOP_WEIGHT: w_nostop = v;
            CFG_CRUISE_WEIGHT:  w_cruise = v;
            CFG_CRUISE_ENABLE:  cruise_on = v[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 0;
    endtask

    task automatic cfg_all(input logic [31:0] inv, stop, ov, un, ns, cr, input bit en);
        cfg_write(CFG_INV_TIME_STEP, inv);
        cfg_write(CFG_STOP_SPEED, stop);
        cfg_write(CFG_OVER_WEIGHT, ov);
        cfg_write(CFG_UNDER_WEIGHT, un);
        cfg_write(CFG_NO_STOP_WEIGHT, ns);
        cfg_write(CFG_CRUISE_WEIGHT, cr);
        cfg_write(CFG_CRUISE_ENABLE, {31'd0, en});
    endtask

    function automatic t_row mk(t_cmd c, int p, int q, int l, int t, int a, int b);
        t_row r;
        r.cmd = c; r.prev = 18'(p); r.curr = 18'(q); r.lim = 16'(l); r.tgt = 16'(t);
        r.lo = 18'(a); r.hi = 18'(b);
        r.typed = 0; r.cost = 0; r.status = ST_OK;
        return r;
    endfunction

    function automatic t_row mk_typed(t_row r, logic [31:0] c, t_status s);
        r.typed = 1; r.cost = c; r.status = s;
        return r;
    endfunction

    // Mostly forward steps whose speed lands near the limit.
    function automatic t_row random_item();
        t_row r;
        int unsigned pick, spd, delta;
        r = mk(CMD_EVAL, 0, 0, 0, 0, 0, 0);
        r.lim = 16'($urandom);
        r.tgt = 16'($urandom);
        r.lo = 18'($urandom);
        r.hi = 18'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
            r.cmd = CMD_CLEAR;
        end else if (pick < 12) begin
            r.cmd = CMD_ADD;
            r.hi = 18'(r.lo + $urandom_range(0, 4000));
            if (r.hi < r.lo) r.hi = 18'h3FFFF;
        end else if (pick < 15) begin
            r.cmd = CMD_NONE;
        end else if (pick < 25) begin
            r.prev = 18'($urandom);
            r.curr = 18'($urandom);
            if ($urandom_range(0, 9) == 0) r.lim = 0;
        end else begin
            if ($urandom_range(0, 1)) r.lim = 16'($urandom_range(1, 3000));
            if ($urandom_range(0, 2) == 0) r.tgt = 16'(r.lim + $urandom_range(0, 400));
            spd = $urandom_range(0, 2 * r.lim + 10);
            if ($urandom_range(0, 3) == 0) spd = $urandom_range(0, 300);
            delta = 32'((spd * 256) / (inv_step == 0 ? 1 : inv_step));
            r.prev = 18'($urandom);
            if (r.prev > 18'h3FFFF - delta) r.prev = 18'(18'h3FFFF - delta);
            r.curr = 18'(r.prev + delta);
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_cost_result e;
        if (i_rst_n && o_valid) begin
            if (pending_costs.size() == 0) begin
                $display("%0t: unexpected result cost=%h status=%0d", $time,
                         o_step_cost, o_status);
                errors++;
            end else begin
                e = pending_costs.pop_front();
                if (o_step_cost !== e.cost) begin
                    $display("%0t: step_cost expected %h actual %h", $time, e.cost,
                             o_step_cost);
                    errors++;
                end
                if (o_status !== e.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, e.status,
                             o_status);
                    errors++;
                end
            end
        end
    end

    initial begin
        t_row dir[$];
        i_rst_n = 0; i_cfg_we = 0; i_cfg_addr = 0; i_cfg_wdata = 0; i_start = 0;
        i_cmd = 0; i_prev_pos = 0; i_curr_pos = 0; i_limit_speed = 0;
        i_target_speed = 0; i_range_lo = 0; i_range_hi = 0;
        inv_step = 256; stop_spd = 205; w_over = 0; w_under = 0; w_nostop = 0;
        w_cruise = 0; cruise_on = 0; zone_count = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1;

        // Reset weights are zero, so every plain step costs nothing.
        dir.push_back(mk_typed(mk(CMD_EVAL, 0, 1024, 1024, 0, 0, 0), 0, ST_OK));
        dir.push_back(mk_typed(mk(CMD_EVAL, 5, 4, 100, 0, 0, 0), 32'hFFFF_FFFF,
                               ST_REVERSE));
        dir.push_back(mk_typed(mk(CMD_EVAL, 0, 18'h3FFFF, 0, 0, 0, 0), 32'hFFFF_FFFF,
                               ST_ZERO_LIMIT));
        dir.push_back(mk_typed(mk(CMD_NONE, 18'h3FFFF, 0, 16'hFFFF, 16'hFFFF, 18'h3FFFF,
                                  0), 0, ST_OK));
        dir.push_back(mk_typed(mk(CMD_CLEAR, 0, 0, 0, 0, 0, 0), 0, ST_OK));
        for (int i = 0; i < MAX_RANGES; i++)
            dir.push_back(mk_typed(mk(CMD_ADD, 0, 0, 0, 0, 1000 * i, 1000 * i + 500),
                                   0, ST_OK));
        dir.push_back(mk_typed(mk(CMD_ADD, 0, 0, 0, 0, 0, 18'h3FFFF), 0, ST_FULL));
        foreach (dir[i]) send_item(dir[i]);
        drain();

        cfg_all(256, 205, 32'h0001_0000, 32'h0001_0000, 32'h0005_0000, 32'h0000_8000,
                1'b1);
        dir.delete();
        dir.push_back(mk(CMD_EVAL, 1000, 1000, 500, 100, 0, 0));
        dir.push_back(mk(CMD_EVAL, 100, 1124, 1024, 1024, 0, 0));
        dir.push_back(mk(CMD_EVAL, 0, 18'h3FFFF, 1, 0, 0, 0));
        dir.push_back(mk(CMD_EVAL, 0, 2048, 1024, 16'hFFFF, 0, 0));
        dir.push_back(mk(CMD_CLEAR, 0, 0, 0, 0, 0, 0));
        dir.push_back(mk(CMD_ADD, 0, 0, 0, 0, 500, 100));
        dir.push_back(mk(CMD_EVAL, 300, 300, 700, 0, 0, 0));
        dir.push_back(mk(CMD_ADD, 0, 0, 0, 0, 0, 18'h3FFFF));
        dir.push_back(mk(CMD_EVAL, 18'h3FFFF, 18'h3FFFF, 16'hFFFF, 0, 0, 0));
        foreach (dir[i]) send_item(dir[i]);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: cfg_all(1, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                           32'hFFFF_FFFF, 1'b1);
                1: cfg_all(16'hFFFF, 16'hFFFF, 0, 0, 0, 0, 1'b0);
                default: cfg_all($urandom_range(1, 2048), $urandom_range(0, 4000),
                                 $urandom_range(0, 1 << 20), $urandom_range(0, 1 << 20),
                                 $urandom, $urandom_range(0, 1 << 18),
                                 1'($urandom_range(0, 1)));
            endcase
            no_idle = (ph == 5);
            repeat (300) send_item(random_item());
            drain();
        end

        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
